>>> rtl/hbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbf_pkg
// types and constants shared by the harmonic bond force block
// ----------------------------------------------------------------------------
package hbf_pkg;

   localparam int K_FRAC = 8;

   // bond as it travels from the front to the back part
   typedef struct packed {
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] dz;
      logic [30:0]        rest_length;
      logic [31:0]        spring_constant;
      logic               start_sum;
   } bond_type;

   // result item
   typedef struct packed {
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic signed [47:0] force_z;
      logic [47:0]        bond_energy;
      logic [62:0]        energy_total;
      logic               zero_length;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_ENERGY,
      ST_DIV,
      ST_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_WRAP,
      FR_PUSH
   } front_state_type;

endpackage
`default_nettype wire

>>> rtl/harmonic_bond_force.sv
`default_nettype none
// ----------------------------------------------------------------------------
// harmonic_bond_force
// harmonic bond force and energy with minimum image wrap
// ----------------------------------------------------------------------------
// One bond in, one result out. The front takes a bond and wraps each axis
// with a serial remainder by the box length, leaving an axis with a zero box
// length unwrapped, then hands the bond through a two entry queue to the
// back. The back squares and sums the separation, finds r one bit per cycle
// with a 36 step square root, forms energy and the running total, then
// divides k*|dev|*|delta| by r one quotient bit per cycle for each axis. When
// r is zero the divide is skipped; the front takes the next bond while the
// back works. Box registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module harmonic_bond_force #(
   parameter int FRAC_BITS = 20
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z,
   // rest_length, spring_constant (zero padded)
   input  wire logic [255:0]  req_tdata,
   // start_sum
   input  wire logic          req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // force_x, force_y, force_z, bond_energy, energy_total (zero padded)
   output logic [255:0]       rsp_tdata,
   // zero_length
   output logic               rsp_tuser,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [30:0]   csr_data
);

   localparam logic [1:0] REG_BOX_X = 2'd0;
   localparam logic [1:0] REG_BOX_Y = 2'd1;
   localparam logic [1:0] REG_BOX_Z = 2'd2;

   logic [30:0] box_x_ff, box_y_ff, box_z_ff;

   // box registers, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= '0; box_y_ff <= '0; box_z_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BOX_X: box_x_ff <= csr_data;
            REG_BOX_Y: box_y_ff <= csr_data;
            REG_BOX_Z: box_z_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   hbf_pkg::bond_type   f_bond, q_bond;
   hbf_pkg::result_type res;
   logic f_valid, f_ready, q_valid, q_ready;

   hbf_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .first_x(req_tdata[31:0]),     .first_y(req_tdata[63:32]),
      .first_z(req_tdata[95:64]),    .second_x(req_tdata[127:96]),
      .second_y(req_tdata[159:128]), .second_z(req_tdata[191:160]),
      .rest_length(req_tdata[222:192]),
      .spring_constant(req_tdata[254:223]),
      .start_sum(req_tuser),
      .box_x(box_x_ff), .box_y(box_y_ff), .box_z(box_z_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_bond(f_bond)
   );

   hbf_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_bond(f_bond),
      .out_valid(q_valid), .out_ready(q_ready), .out_bond(q_bond)
   );

   hbf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_bond(q_bond),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {1'b0, res.energy_total, res.bond_energy,
                       res.force_z, res.force_y, res.force_x};
   assign rsp_tuser = res.zero_length;

   // a result is held until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // zero length means zero force
   a_zero_force: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[143:0] == '0)
      else $error("force nonzero at zero length");
   // a box x write lands in its register
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == REG_BOX_X |=> box_x_ff == $past(csr_data))
      else $error("box register not written");

endmodule
`default_nettype wire

>>> rtl/hbf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbf_front
// forms the separation per axis and wraps it by the minimum image rule
// ----------------------------------------------------------------------------
module hbf_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [31:0]       first_x,
   input  wire logic [31:0]       first_y,
   input  wire logic [31:0]       first_z,
   input  wire logic [31:0]       second_x,
   input  wire logic [31:0]       second_y,
   input  wire logic [31:0]       second_z,
   input  wire logic [30:0]       rest_length,
   input  wire logic [31:0]       spring_constant,
   input  wire logic              start_sum,
   input  wire logic [30:0]       box_x,
   input  wire logic [30:0]       box_y,
   input  wire logic [30:0]       box_z,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hbf_pkg::bond_type      out_bond
);

   hbf_pkg::front_state_type state_ff, state_in;
   hbf_pkg::bond_type        bond_ff, bond_in;
   logic [1:0]               axis_ff, axis_in;
   logic [5:0]               wstep_ff, wstep_in;   // 0 setup, 1..34 remainder bits, 35 store
   logic [33:0]              mag_ff, mag_in;
   logic                     tneg_ff, tneg_in;
   logic [30:0]              rem_ff, rem_in;

   logic signed [33:0] dsel, wrapped;
   logic [30:0]        len, mres;
   logic [34:0]        t;
   logic [31:0]        rtry;

   // shifted separation t = delta + l/2, reduced mod l one bit per cycle
   // on its magnitude, then folded back for negative t
   always_comb begin
      unique case (axis_ff)
         2'd0:    begin dsel = bond_ff.dx; len = box_x; end
         2'd1:    begin dsel = bond_ff.dy; len = box_y; end
         default: begin dsel = bond_ff.dz; len = box_z; end
      endcase
      t       = {dsel[33], dsel} + {5'd0, len[30:1]};
      rtry    = {rem_ff, mag_ff[33]};
      mres    = (tneg_ff && rem_ff != '0) ? (len - rem_ff) : rem_ff;
      wrapped = {3'b000, mres} - {4'b0000, len[30:1]};
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      wstep_in = wstep_ff;
      unique case (state_ff)
         hbf_pkg::FR_IDLE: begin
            if (in_valid) begin
               state_in = hbf_pkg::FR_WRAP;
               axis_in  = '0;
               wstep_in = '0;
            end
         end
         hbf_pkg::FR_WRAP: begin
            if ((wstep_ff == 6'd0 && len == '0) || wstep_ff == 6'd35) begin
               if (axis_ff == 2'd2) state_in = hbf_pkg::FR_PUSH;
               axis_in  = axis_ff + 2'd1;
               wstep_in = '0;
            end else begin
               wstep_in = wstep_ff + 6'd1;
            end
         end
         hbf_pkg::FR_PUSH: if (out_ready) state_in = hbf_pkg::FR_IDLE;
         default:          state_in = hbf_pkg::FR_IDLE;
      endcase
   end

   always_comb begin
      bond_in = bond_ff;
      mag_in  = mag_ff;
      tneg_in = tneg_ff;
      rem_in  = rem_ff;
      if (state_ff == hbf_pkg::FR_IDLE) begin
         bond_in.dx = 34'(signed'(second_x)) - 34'(signed'(first_x));
         bond_in.dy = 34'(signed'(second_y)) - 34'(signed'(first_y));
         bond_in.dz = 34'(signed'(second_z)) - 34'(signed'(first_z));
         bond_in.rest_length     = rest_length;
         bond_in.spring_constant = spring_constant;
         bond_in.start_sum       = start_sum;
      end else if (state_ff == hbf_pkg::FR_WRAP) begin
         if (wstep_ff == 6'd0) begin
            mag_in  = t[34] ? 34'(-t) : t[33:0];
            tneg_in = t[34];
            rem_in  = '0;
         end else if (wstep_ff == 6'd35) begin
            unique case (axis_ff)
               2'd0:    bond_in.dx = wrapped;
               2'd1:    bond_in.dy = wrapped;
               default: bond_in.dz = wrapped;
            endcase
         end else begin
            mag_in = {mag_ff[32:0], 1'b0};
            if (rtry >= {1'b0, len}) rem_in = 31'(rtry - {1'b0, len});
            else                     rem_in = rtry[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbf_pkg::FR_IDLE;
         axis_ff  <= '0;
         wstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         wstep_ff <= wstep_in;
      end
      bond_ff <= bond_in;
      mag_ff  <= mag_in;
      tneg_ff <= tneg_in;
      rem_ff  <= rem_in;
   end

   assign in_ready  = (state_ff == hbf_pkg::FR_IDLE);
   assign out_valid = (state_ff == hbf_pkg::FR_PUSH);
   assign out_bond  = bond_ff;

endmodule
`default_nettype wire

>>> rtl/hbf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbf_queue
// two entry queue between front and back
// ----------------------------------------------------------------------------
module hbf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire hbf_pkg::bond_type in_bond,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hbf_pkg::bond_type      out_bond
);

   hbf_pkg::bond_type mem_ff [2];
   logic              wp_ff, rp_ff;
   logic [1:0]        cnt_ff;
   logic              push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_bond  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_bond;
   end

endmodule
`default_nettype wire

>>> rtl/hbf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbf_back
// distance by bit serial square root, energy, force by shared divider
// ----------------------------------------------------------------------------
module hbf_back #(
   parameter int FRAC_BITS = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire hbf_pkg::bond_type in_bond,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hbf_pkg::result_type    out_result
);

   localparam int ESH = FRAC_BITS + hbf_pkg::K_FRAC + 1;

   hbf_pkg::back_state_type state_ff, state_in;
   hbf_pkg::bond_type       bond_ff;
   hbf_pkg::result_type     res_ff;

   logic [67:0]  sq_ff;       // sum of squares, below 3 * 2^66
   logic [35:0]  root_ff;
   logic [5:0]   step_ff;
   logic [1:0]   axis_ff;
   logic [3:0]   phase_ff;
   logic [62:0]  acc_ff;

   logic [33:0]  ax, ay, az, asel;
   logic [67:0]  px_ff, py_ff, pz_ff;
   logic [35:0]  trial;
   logic [71:0]  trial_sq;

   logic signed [36:0] dev;
   logic [35:0]  adev_ff;
   logic         dneg_ff;
   logic [71:0]  adev2_ff;
   logic [103:0] e_ff;
   logic [67:0]  ka_ff;       // k * |dev|
   logic [101:0] num_ff;      // k * |dev| * |delta|
   logic [101:0] rem_ff;
   logic [101:0] quo_ff;
   logic [6:0]   dstep_ff;
   logic [43:0]  dvs;
   logic [47:0]  energy;
   logic [63:0]  tsum;
   logic         fneg;
   logic [102:0] rtry;
   logic signed [47:0] fval;
   logic [67:0]  elo, ehi, nlo, nhi;   // partial products, low and high halves added in turn

   assign ax = bond_ff.dx[33] ? 34'(-bond_ff.dx) : 34'(bond_ff.dx);
   assign ay = bond_ff.dy[33] ? 34'(-bond_ff.dy) : 34'(bond_ff.dy);
   assign az = bond_ff.dz[33] ? 34'(-bond_ff.dz) : 34'(bond_ff.dz);

   always_comb begin
      unique case (axis_ff)
         2'd0:    begin asel = ax; fneg = dneg_ff ^ bond_ff.dx[33]; end
         2'd1:    begin asel = ay; fneg = dneg_ff ^ bond_ff.dy[33]; end
         default: begin asel = az; fneg = dneg_ff ^ bond_ff.dz[33]; end
      endcase
   end

   assign trial    = root_ff | (36'd1 << step_ff);
   assign trial_sq = trial * trial;
   assign dev      = 37'(signed'({1'b0, root_ff})) - 37'(signed'({6'd0, bond_ff.rest_length}));
   assign dvs      = {root_ff, 8'd0};
   assign rtry     = {rem_ff, num_ff[101 - dstep_ff]};

   assign elo = adev2_ff[35:0] * bond_ff.spring_constant;
   assign ehi = adev2_ff[71:36] * bond_ff.spring_constant;
   assign nlo = ka_ff[33:0] * asel;
   assign nhi = ka_ff[67:34] * asel;

   always_comb begin
      logic [103:0] es;
      es = e_ff >> ESH;
      energy = (es[103:48] != '0) ? 48'hFFFF_FFFF_FFFF : es[47:0];
      tsum   = {1'b0, acc_ff} + {16'd0, energy};
   end

   always_comb begin
      if (quo_ff[101:47] != '0) fval = fneg ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      else                      fval = fneg ? -48'(quo_ff[46:0]) : 48'(quo_ff[46:0]);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbf_pkg::ST_IDLE:   if (in_valid) state_in = hbf_pkg::ST_SQRT;
         hbf_pkg::ST_SQRT:   if (phase_ff == 4'd2 && step_ff == 6'd0) state_in = hbf_pkg::ST_ENERGY;
         hbf_pkg::ST_ENERGY: if (phase_ff == 4'd5)
                                state_in = (root_ff == '0) ? hbf_pkg::ST_DONE : hbf_pkg::ST_DIV;
         hbf_pkg::ST_DIV:    if (phase_ff == 4'd2 && axis_ff == 2'd2) state_in = hbf_pkg::ST_DONE;
         hbf_pkg::ST_DONE:   if (out_ready) state_in = hbf_pkg::ST_IDLE;
         default:            state_in = hbf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbf_pkg::ST_IDLE;
         acc_ff   <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            hbf_pkg::ST_IDLE: begin
               phase_ff <= '0;
               if (in_valid) begin
                  bond_ff <= in_bond;
                  root_ff <= '0;
                  step_ff <= 6'd35;
               end
            end
            hbf_pkg::ST_SQRT: begin
               // squares and their sum first, then one root bit per cycle
               if (phase_ff == 4'd0) begin
                  px_ff <= ax * ax; py_ff <= ay * ay; pz_ff <= az * az;
                  phase_ff <= 4'd1;
               end else if (phase_ff == 4'd1) begin
                  sq_ff <= px_ff + py_ff + pz_ff;
                  phase_ff <= 4'd2;
               end else begin
                  if (trial_sq <= {4'd0, sq_ff}) root_ff <= trial;
                  step_ff <= step_ff - 6'd1;
                  if (step_ff == 6'd0) phase_ff <= 4'd0;
               end
            end
            hbf_pkg::ST_ENERGY: begin
               phase_ff <= phase_ff + 4'd1;
               if (phase_ff == 4'd0) begin
                  adev_ff <= dev[36] ? 36'(-dev) : 36'(dev);
                  dneg_ff <= dev[36];
               end else if (phase_ff == 4'd1) begin
                  adev2_ff <= adev_ff * adev_ff;
                  ka_ff    <= bond_ff.spring_constant * adev_ff;
               end else if (phase_ff == 4'd2) begin
                  // k * dev^2, low half then high half
                  e_ff <= {36'd0, elo};
               end else if (phase_ff == 4'd3) begin
                  e_ff <= e_ff + {ehi, 36'd0};
               end else if (phase_ff == 4'd4) begin
                  res_ff.bond_energy <= energy;
                  if (bond_ff.start_sum) acc_ff <= {15'd0, energy};
                  else acc_ff <= tsum[63] ? 63'h7FFF_FFFF_FFFF_FFFF : tsum[62:0];
               end else begin
                  res_ff.energy_total <= acc_ff;
                  res_ff.zero_length  <= (root_ff == '0);
                  res_ff.force_x <= '0; res_ff.force_y <= '0; res_ff.force_z <= '0;
                  axis_ff  <= '0;
                  phase_ff <= '0;
               end
            end
            hbf_pkg::ST_DIV: begin
               // numerator in two halves, then restoring division, one quotient bit per cycle
               if (phase_ff == 4'd0) begin
                  num_ff   <= {34'd0, nlo};
                  phase_ff <= 4'd1;
               end else if (phase_ff == 4'd1) begin
                  num_ff <= num_ff + {nhi, 34'd0};
                  rem_ff <= '0; quo_ff <= '0; dstep_ff <= '0;
                  phase_ff <= 4'd3;
               end else if (phase_ff == 4'd3) begin
                  if (rtry >= {59'd0, dvs}) begin
                     rem_ff <= 102'(rtry - {59'd0, dvs});
                     quo_ff <= {quo_ff[100:0], 1'b1};
                  end else begin
                     rem_ff <= rtry[101:0];
                     quo_ff <= {quo_ff[100:0], 1'b0};
                  end
                  dstep_ff <= dstep_ff + 7'd1;
                  if (dstep_ff == 7'd101) phase_ff <= 4'd2;
               end else begin
                  unique case (axis_ff)
                     2'd0:    res_ff.force_x <= fval;
                     2'd1:    res_ff.force_y <= fval;
                     default: res_ff.force_z <= fval;
                  endcase
                  axis_ff  <= axis_ff + 2'd1;
                  phase_ff <= '0;
               end
            end
            default: phase_ff <= '0;
         endcase
      end
   end

   assign in_ready   = (state_ff == hbf_pkg::ST_IDLE);
   assign out_valid  = (state_ff == hbf_pkg::ST_DONE);
   assign out_result = res_ff;

endmodule
`default_nettype wire
